[rtl/ccpc_pkg.sv]
// ----------------------------------------------------------------------------
// ccpc_pkg
// Shared types, constants and the crc-16/modbus word update for the
// command packet checker.
// ----------------------------------------------------------------------------
package ccpc_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] BYTE_MASK = 16'h00FF;

    localparam int unsigned NUM_VERDICTS = 5;
    localparam int unsigned CFG_AW      = 4;

    // register indexes on the configuration port
    localparam logic [1:0] REG_HEADER  = 2'd0;
    localparam logic [1:0] REG_PAYLOAD = 2'd1;
    localparam logic [1:0] REG_COMMAND = 2'd2;

    typedef enum logic [2:0] {
        V_OK      = 3'd0,
        V_HEADER  = 3'd1,
        V_LENGTH  = 3'd2,
        V_CRC     = 3'd3,
        V_UNKNOWN = 3'd4
    } t_verdict;

    typedef struct packed {
        t_verdict    verdict;
        logic [15:0] command_id;
        logic [31:0] parameter_res;
    } t_event;

    // front to queue
    typedef struct packed {
        logic   valid;
        t_event ev;
    } t_push;

    // queue to back
    typedef struct packed {
        logic   valid;
        t_event ev;
    } t_head;

    typedef struct packed {
        logic [15:0] header_word;
        logic [4:0]  payload_limit;
        logic [15:0] command_limit;
    } t_cfg;

    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ (16'(b) & BYTE_MASK);
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // high byte first
    function automatic logic [15:0] crc_word(logic [15:0] crc, logic [15:0] w);
        return crc_byte(crc_byte(crc, w[15:8]), w[7:0]);
    endfunction

endpackage

[rtl/ccpc_if.sv]
// ----------------------------------------------------------------------------
// ccpc channel interfaces
// Word input channel and verdict result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ccpc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;
    logic        start_req;

    modport source(output valid, output word, output start_req, input ready);
    modport sink(input valid, input word, input start_req, output ready);
endinterface

interface ccpc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic [15:0] command_id;
    logic [31:0] parameter_res;
    logic [31:0] verdict_count;

    modport source(output valid, output verdict, output command_id,
                   output parameter_res, output verdict_count, input ready);
    modport sink(input valid, input verdict, input command_id,
                 input parameter_res, input verdict_count, output ready);
endinterface

[rtl/ccpc_front.sv]
// ----------------------------------------------------------------------------
// ccpc_front
// Word parser: tracks the packet position, runs the crc and pushes one
// verdict event per finished packet into the queue.
// ----------------------------------------------------------------------------
module ccpc_front #(
    parameter int unsigned MAX_PAYLOAD = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [15:0]   i_word,
    input  logic          i_start_req,
    input  logic          i_full,
    input  ccpc_pkg::t_cfg i_cfg,
    output logic          o_ready,
    output ccpc_pkg::t_push o_push
);
    import ccpc_pkg::*;

    localparam int unsigned LW = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned IW = $clog2(MAX_PAYLOAD + 4);

    logic          r_open,  n_open;
    logic [IW-1:0] r_index, n_index;
    logic [15:0]   r_crc,   n_crc;
    logic [15:0]   r_cmd,   n_cmd;
    logic [LW-1:0] r_len,   n_len;
    logic [31:0]   r_param, n_param;

    logic          accept;
    logic          open_eff;
    logic [IW-1:0] idx;
    logic [15:0]   crc;
    logic [15:0]   cmd;
    logic [LW-1:0] len;
    logic [31:0]   param;
    logic          emit;
    t_verdict      verdict;
    logic          cmd_ok;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        // a start drops any packet in progress
        open_eff = i_start_req || r_open;
        idx      = i_start_req ? '0       : r_index;
        crc      = i_start_req ? CRC_INIT : r_crc;
        cmd      = i_start_req ? '0       : r_cmd;
        len      = i_start_req ? '0       : r_len;
        param    = i_start_req ? '0       : r_param;
        emit     = 1'b0;
        verdict  = V_OK;
        cmd_ok   = (cmd != 16'd0) && (cmd <= i_cfg.command_limit);

        if (idx == IW'(0)) begin
            if (i_word != i_cfg.header_word) begin
                emit    = 1'b1;
                verdict = V_HEADER;
            end
        end else if (idx == IW'(1)) begin
            cmd = i_word;
        end else if (idx == IW'(2)) begin
            if ((i_word > 16'(i_cfg.payload_limit)) || (i_word > 16'(MAX_PAYLOAD))) begin
                emit    = 1'b1;
                verdict = V_LENGTH;
            end else begin
                len = i_word[LW-1:0];
            end
        end else if ((IW+1)'(idx) < (IW+1)'(len) + (IW+1)'(3)) begin
            if (idx == IW'(3)) begin
                param = (len >= LW'(2)) ? {i_word, 16'h0000} : {16'h0000, i_word};
            end else if (idx == IW'(4)) begin
                param = param | {16'h0000, i_word};
            end
        end else begin
            emit    = 1'b1;
            verdict = (i_word != crc) ? V_CRC : (cmd_ok ? V_OK : V_UNKNOWN);
        end

        n_open  = r_open;
        n_index = r_index;
        n_crc   = r_crc;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_param = r_param;
        o_push.valid            = 1'b0;
        o_push.ev.verdict       = verdict;
        o_push.ev.command_id    = (verdict == V_OK || verdict == V_UNKNOWN) ? cmd : 16'h0000;
        o_push.ev.parameter_res = (verdict == V_OK || verdict == V_UNKNOWN) ? param : 32'h0;

        if (accept && open_eff) begin
            n_cmd   = cmd;
            n_len   = len;
            n_param = param;
            if (emit) begin
                o_push.valid = 1'b1;
                n_open       = 1'b0;
                n_index      = idx;
                n_crc        = crc;
            end else begin
                n_open  = 1'b1;
                n_index = idx + IW'(1);
                n_crc   = crc_word(crc, i_word);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_index <= '0;
            r_crc   <= CRC_INIT;
            r_cmd   <= '0;
            r_len   <= '0;
            r_param <= '0;
        end else begin
            r_open  <= n_open;
            r_index <= n_index;
            r_crc   <= n_crc;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_param <= n_param;
        end
    end

endmodule

[rtl/ccpc_queue.sv]
// ----------------------------------------------------------------------------
// ccpc_queue
// Two-entry event queue between the word parser and the result stage.
// ----------------------------------------------------------------------------
module ccpc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ccpc_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_full,
    output ccpc_pkg::t_head o_head
);
    import ccpc_pkg::*;

    t_event     r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;

    assign o_full       = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.ev    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push.valid;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + 2'(i_push.valid) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("event pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("event popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2 && !i_pop) |=> (r_count == 2'd2))
        else $error("full queue lost an entry without a pop");

endmodule

[rtl/ccpc_back.sv]
// ----------------------------------------------------------------------------
// ccpc_back
// Result stage: bumps the per-verdict counter and holds the result item
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module ccpc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ccpc_pkg::t_head i_head,
    input  logic            i_ready,
    output logic            o_pop,
    output logic            o_valid,
    output logic [2:0]      o_verdict,
    output logic [15:0]     o_command_id,
    output logic [31:0]     o_parameter_res,
    output logic [31:0]     o_verdict_count
);
    import ccpc_pkg::*;

    logic [31:0] r_counters [NUM_VERDICTS];
    logic        r_valid;
    t_event      r_ev;
    logic [31:0] r_count;
    logic [31:0] n_count;

    assign o_pop  = i_head.valid && (!r_valid || i_ready);
    assign n_count = r_counters[i_head.ev.verdict] + 32'd1;

    assign o_valid         = r_valid;
    assign o_verdict       = r_ev.verdict;
    assign o_command_id    = r_ev.command_id;
    assign o_parameter_res = r_ev.parameter_res;
    assign o_verdict_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int k = 0; k < NUM_VERDICTS; k++) begin
                r_counters[k] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_valid                         <= 1'b1;
                r_counters[i_head.ev.verdict]   <= n_count;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ev    <= i_head.ev;
            r_count <= n_count;
        end
    end

endmodule

[rtl/crc16_command_packet_checker.sv]
// ----------------------------------------------------------------------------
// crc16_command_packet_checker
// Packet checker: header, length, crc-16/modbus and command range checks,
// one verdict item per packet with a running count per verdict.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one 16-bit packet word per item; start_req marks word 0.
//   o_res  : one item per finished packet: verdict, command id, 32-bit
//            parameter and the updated wrapping count for that verdict.
//   apb    : header_word at 0x0, payload_limit at 0x4, command_limit at 0x8;
//            write only while no packet result is outstanding.
//   Throughput is one word per cycle while the queue is not full; the crc
//   word update is combinational xor logic in the parser.
//   The last word of a packet reaches the result item through the parser
//   push into a 2-entry queue, then the counter/output register.
//   When o_res stalls, one result waits in the output register and two in
//   the queue; i_in.ready drops once the queue is full, so words stay
//   accepted until three results are pending.
//   Reset clears the counters, the packet state and loads the register
//   defaults (header 0, payload limit 16, command limit 16).
// ----------------------------------------------------------------------------
module crc16_command_packet_checker #(
    parameter int unsigned MAX_PAYLOAD = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ccpc_in_if.sink                      i_in,
    ccpc_out_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ccpc_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import ccpc_pkg::*;

    t_cfg  r_cfg;
    t_push push;
    t_head head;
    logic  full;
    logic  pop;
    logic  cfg_wr;
    logic [1:0] reg_idx;
    logic [2:0] res_verdict;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_idx)
            REG_HEADER:  prdata = {16'h0000, r_cfg.header_word};
            REG_PAYLOAD: prdata = {27'h0, r_cfg.payload_limit};
            REG_COMMAND: prdata = {16'h0000, r_cfg.command_limit};
            default:     prdata = 32'h0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_word   <= 16'd0;
            r_cfg.payload_limit <= 5'd16;
            r_cfg.command_limit <= 16'd16;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_HEADER:  r_cfg.header_word   <= pwdata[15:0];
                REG_PAYLOAD: r_cfg.payload_limit <= pwdata[4:0];
                REG_COMMAND: r_cfg.command_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    ccpc_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .i_word     (i_in.word),
        .i_start_req(i_in.start_req),
        .i_full     (full),
        .i_cfg      (r_cfg),
        .o_ready    (i_in.ready),
        .o_push     (push)
    );

    ccpc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_pop  (pop),
        .o_full (full),
        .o_head (head)
    );

    ccpc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_ready        (o_res.ready),
        .o_pop          (pop),
        .o_valid        (o_res.valid),
        .o_verdict      (res_verdict),
        .o_command_id   (o_res.command_id),
        .o_parameter_res(o_res.parameter_res),
        .o_verdict_count(o_res.verdict_count)
    );

    assign o_res.verdict = res_verdict;

endmodule

[bench/tb_crc16_command_packet_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc16_command_packet_checker
// Feeds framed packets word by word through the checker under random
// handshake gaps and several register settings. A cycle-free model of the
// parser predicts each verdict item, which is checked against the result port.
// ----------------------------------------------------------------------------
module tb_crc16_command_packet_checker;

    import ccpc_pkg::*;

    localparam int unsigned MAX_PAYLOAD = 16;
    localparam logic [1:0]  REG_UNUSED  = 2'd3;

    typedef struct {
        t_verdict    verdict;
        logic [15:0] command_id;
        logic [31:0] parameter_res;
        logic [31:0] count;
    } t_verdict_item;

    // crc-16/modbus, one bit at a time: high byte first, each byte lsb first
    function automatic logic [15:0] crc_next(logic [15:0] crc, logic [15:0] w);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int k = 0; k < 16; k++) begin
            fb = r[0] ^ w[(k < 8) ? (k + 8) : (k - 8)];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    class t_verdict_tracker;
        logic [15:0]   cfg_header;
        logic [4:0]    cfg_payload;
        logic [15:0]   cfg_command;
        int unsigned   word_pos;
        logic [15:0]   crc;
        bit            open;
        logic [15:0]   cmd;
        logic [15:0]   len;
        logic [31:0]   param;
        logic [31:0]   tally[NUM_VERDICTS];
        t_verdict_item pending[$];
        int            posted;
        int            checked;
        int            errors;

        function new();
            cfg_header  = 16'h0000;
            cfg_payload = 5'd16;
            cfg_command = 16'd16;
            word_pos    = 0;
            crc         = CRC_INIT;
            open        = 0;
            cmd         = '0;
            len         = '0;
            param       = '0;
            foreach (tally[i]) tally[i] = '0;
            posted  = 0;
            checked = 0;
            errors  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_HEADER:  cfg_header  = v[15:0];
                REG_PAYLOAD: cfg_payload = v[4:0];
                REG_COMMAND: cfg_command = v[15:0];
                default: ;
            endcase
        endfunction

        function int unsigned length_cap();
            return (cfg_payload < MAX_PAYLOAD) ? cfg_payload : MAX_PAYLOAD;
        endfunction

        function void post(t_verdict v, logic [15:0] c, logic [31:0] p);
            t_verdict_item e;
            tally[v]        = tally[v] + 1;
            e.verdict       = v;
            e.command_id    = c;
            e.parameter_res = p;
            e.count         = tally[v];
            pending.push_back(e);
            posted++;
            open = 0;
        endfunction

        // returns 1 when the word was taken into a packet
        function bit take_word(logic [15:0] w, logic s);
            if (s) begin
                open     = 1;
                word_pos = 0;
                crc      = CRC_INIT;
                cmd      = '0;
                len      = '0;
                param    = '0;
            end
            if (!open) begin
                return 0;
            end
            if (word_pos == 0) begin
                if (w != cfg_header) begin
                    post(V_HEADER, '0, '0);
                    return 1;
                end
            end else if (word_pos == 1) begin
                cmd = w;
            end else if (word_pos == 2) begin
                if (w > length_cap()) begin
                    post(V_LENGTH, '0, '0);
                    return 1;
                end
                len = w;
            end else if (word_pos < 3 + len) begin
                if (word_pos == 3) begin
                    param = (len >= 2) ? {w, 16'h0000} : {16'h0000, w};
                end else if (word_pos == 4) begin
                    param = param | {16'h0000, w};
                end
            end else begin
                if (w != crc) begin
                    post(V_CRC, '0, '0);
                end else if (cmd >= 1 && cmd <= cfg_command) begin
                    post(V_OK, cmd, param);
                end else begin
                    post(V_UNKNOWN, cmd, param);
                end
                return 1;
            end
            crc = crc_next(crc, w);
            word_pos++;
            return 1;
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        function void check_verdict(logic [2:0] v, logic [15:0] c, logic [31:0] p,
                                    logic [31:0] n);
            t_verdict_item e;
            if (pending.size() == 0) begin
                note_error($sformatf("unexpected item verdict=%0d cmd=%h par=%h cnt=%0d",
                                     v, c, p, n));
                return;
            end
            e = pending.pop_front();
            checked++;
            if (v !== e.verdict || c !== e.command_id || p !== e.parameter_res ||
                n !== e.count) begin
                note_error($sformatf({"exp verdict=%0d cmd=%h par=%h cnt=%0d, ",
                                      "got verdict=%0d cmd=%h par=%h cnt=%0d"},
                                     e.verdict, e.command_id, e.parameter_res, e.count,
                                     v, c, p, n));
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [CFG_AW-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    ccpc_in_if  word_ch();
    ccpc_out_if verdict_ch();

    t_verdict_tracker board;
    bit               in_quiet;
    bit               out_quiet;
    int               res_wait;
    int               words_fed;
    int               settings_used;

    crc16_command_packet_checker #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (word_ch),
        .o_res   (verdict_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic int draw_gap(bit quiet);
        if (quiet || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // result side: check every accepted item, then stall a random while
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_wait = 0;
            verdict_ch.ready <= 1'b0;
        end else begin
            if (verdict_ch.valid && verdict_ch.ready) begin
                board.check_verdict(verdict_ch.verdict, verdict_ch.command_id,
                                    verdict_ch.parameter_res, verdict_ch.verdict_count);
                res_wait = draw_gap(out_quiet);
            end else if (res_wait > 0) begin
                res_wait--;
            end
            verdict_ch.ready <= (res_wait == 0);
        end
    end

    task automatic send_word(logic [15:0] w, logic s);
        int gap;
        gap = draw_gap(in_quiet);
        if (gap > 0) begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        word_ch.valid     <= 1'b1;
        word_ch.word      <= w;
        word_ch.start_req <= s;
        do @(posedge i_clk); while (!word_ch.ready);
        if (board.take_word(w, s)) begin
            words_fed++;
        end
    endtask

    // build a packet with a matching or broken crc; cut_at > 0 sends only that
    // many words so the next start drops it
    task automatic send_packet(logic [15:0] hdr, logic [15:0] cmd, logic [15:0] len,
                               bit crc_ok, int cut_at);
        logic [15:0] words[$];
        logic [15:0] crc;
        int          n;
        words = {hdr, cmd, len};
        n     = (len <= board.length_cap()) ? len : 0;
        repeat (n) words.push_back(16'($urandom_range(0, 65535)));
        crc = CRC_INIT;
        foreach (words[i]) crc = crc_next(crc, words[i]);
        if (!crc_ok) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        words.push_back(crc);
        if (cut_at > 0 && cut_at < words.size()) begin
            n = cut_at;
        end else begin
            n = words.size();
        end
        for (int i = 0; i < n; i++) begin
            send_word(words[i], i == 0);
        end
    endtask

    task automatic rand_packet();
        logic [15:0] hdr;
        logic [15:0] cmd;
        logic [15:0] len;
        int unsigned cap;
        int unsigned cmd_top;
        cap     = board.length_cap();
        cmd_top = (board.cfg_command == 0) ? 1 : board.cfg_command;
        hdr     = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                              : board.cfg_header;
        case ($urandom_range(0, 5))
            0:       cmd = 16'h0000;
            1:       cmd = board.cfg_command;
            2:       cmd = board.cfg_command + 16'd1;
            3:       cmd = 16'($urandom_range(0, 65535));
            default: cmd = 16'($urandom_range(1, cmd_top));
        endcase
        case ($urandom_range(0, 9))
            6, 7:    len = 16'($urandom_range(0, cap));
            8:       len = 16'(cap + 1);
            9:       len = 16'($urandom_range(0, 65535));
            default: len = 16'($urandom_range(0, (cap < 3) ? cap : 3));
        endcase
        // stray word, ignored unless a cut packet is still open
        if ($urandom_range(0, 19) == 0) begin
            send_word(16'($urandom_range(0, 65535)), 1'b0);
        end
        send_packet(hdr, cmd, len, $urandom_range(0, 19) < 17,
                    ($urandom_range(0, 11) == 0) ? $urandom_range(1, 4) : 0);
    endtask

    // wait until all verdicts are in and the pipeline has drained
    task automatic settle();
        word_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, v);
    endtask

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [31:0] hdr_v;
        logic [31:0] pay_v;
        logic [31:0] cmd_v;
        int          phase;
        int          phase_end;
        board         = new();
        words_fed     = 0;
        settings_used = 1;
        in_quiet      = 0;
        out_quiet     = 0;
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        word_ch.valid      <= 1'b0;
        word_ch.word       <= '0;
        word_ch.start_req  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part on the reset settings
        send_word(16'($urandom_range(0, 65535)), 1'b0);  // no packet open
        send_packet(16'h0000, 16'd1, 16'd0, 1, 0);         // ok, empty payload
        send_packet(16'hFFFF, 16'd1, 16'd0, 1, 1);         // header error
        send_packet(16'h0000, 16'd5, 16'd17, 1, 3);        // length above limit
        send_packet(16'h0000, 16'd3, 16'd2, 1, 2);         // dropped by next start
        send_packet(16'h0000, 16'd16, 16'd2, 1, 0);        // ok, two-word parameter
        send_packet(16'h0000, 16'd7, 16'd0, 0, 0);         // bad crc
        send_packet(16'h0000, 16'd17, 16'd1, 1, 0);        // command above limit
        settle();
        write_reg(REG_UNUSED, $urandom);

        phase     = 0;
        phase_end = words_fed;
        while (words_fed < 400) begin
            settle();
            case (phase)
                0: begin
                    hdr_v = 32'h0000_FFFF; pay_v = 32'd0;  cmd_v = 32'h0000_FFFF;
                end
                1: begin
                    hdr_v = 32'h0;         pay_v = 32'd31; cmd_v = 32'd1;
                end
                2: begin
                    hdr_v = $urandom;      pay_v = 32'd16; cmd_v = 32'd0;
                end
                default: begin
                    hdr_v = $urandom;
                    pay_v = $urandom_range(0, 31);
                    case ($urandom_range(0, 3))
                        0:       cmd_v = $urandom_range(1, 32);
                        1:       cmd_v = $urandom;
                        default: cmd_v = $urandom_range(1, 20);
                    endcase
                end
            endcase
            write_reg(REG_HEADER, hdr_v);
            write_reg(REG_PAYLOAD, pay_v);
            write_reg(REG_COMMAND, cmd_v);
            settings_used++;
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            phase_end = words_fed + 90;
            while (words_fed < phase_end) begin
                rand_packet();
            end
            phase++;
        end

        settle();
        repeat (10) @(posedge i_clk);
        $display("%0d packet words taken, %0d verdict items checked, %0d register settings",
                 words_fed, board.checked, settings_used);
        $display("verdicts ok %0d, header %0d, length %0d, crc %0d, unknown command %0d",
                 board.tally[V_OK], board.tally[V_HEADER], board.tally[V_LENGTH],
                 board.tally[V_CRC], board.tally[V_UNKNOWN]);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
